[rtl/core/ffpa_pkg.sv]
// shared types and constants for the first-fit partition allocator
package ffpa_pkg;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOSPACE  = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_ZERO     = 3'd4;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam int SIZE_W    = 17;
    localparam int OWNER_W   = 16;
    localparam int ADDR_BITS = 16;

    // compare results of the shared unit
    typedef struct packed {
        logic len_ge;
        logic len_eq;
        logic owner_eq;
    } ffpa_cmp_t;

endpackage

[rtl/core/ffpa_cmp.sv]
// shared compare unit: length against request, owner against request
module ffpa_cmp
(
    input  logic [ffpa_pkg::SIZE_W-1:0]  entry_len,
    input  logic [ffpa_pkg::SIZE_W-1:0]  req_len,
    input  logic [ffpa_pkg::OWNER_W-1:0] entry_owner,
    input  logic [ffpa_pkg::OWNER_W-1:0] req_owner,
    output ffpa_pkg::ffpa_cmp_t          cmp
);
    import ffpa_pkg::*;

    always_comb
    begin
        cmp.len_ge   = (entry_len >= req_len);
        cmp.len_eq   = (entry_len == req_len);
        cmp.owner_eq = (entry_owner == req_owner);
    end

endmodule

[rtl/core/first_fit_partition_allocator_unit.sv]
// top level of the first-fit partition allocator with coalescing
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+--------------------
//  command   | opcode owner_id request_size              | start & !busy
//  result    | status address length free_total          | done, one cycle
//  config    | memory_size_data                          | memory_size_we
//
// one command is finished before the next is accepted (busy): the
// table is walked one entry a cycle through the shared compare unit, and a
// split or a merge moves the entries above the hit one entry a cycle.
// reset (or a memory_size write) leaves one free partition covering memory.
// results cannot be stalled; busy stays high through the done cycle.
module first_fit_partition_allocator_unit
#(
    parameter int MAX_PARTS = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        opcode,
    input  logic [15:0]                 owner_id,
    input  logic [16:0]                 request_size,
    input  logic                        memory_size_we,
    input  logic [16:0]                 memory_size_data,
    output logic                        done,
    output logic [2:0]                  status,
    output logic [15:0]                 address,
    output logic [16:0]                 length,
    output logic [16:0]                 free_total
);
    import ffpa_pkg::*;

    localparam int IW = $clog2(MAX_PARTS);
    localparam int CW = $clog2(MAX_PARTS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PARTS);
    localparam logic [17:0] CAP = 18'(1) << ADDR_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_OPEN  = 3'd2;
    localparam logic [2:0] S_SPLIT = 3'd3;
    localparam logic [2:0] S_MRGHI = 3'd4;
    localparam logic [2:0] S_MRGLO = 3'd5;
    localparam logic [2:0] S_DROP  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // partition table, one entry per row
    logic [15:0] p_start [MAX_PARTS];
    logic [16:0] p_len   [MAX_PARTS];
    logic        p_free  [MAX_PARTS];
    logic [15:0] p_owner [MAX_PARTS];

    logic [2:0]    state_reg;
    logic [CW-1:0] count_reg;
    logic [16:0]   free_reg;
    logic [IW-1:0] idx_reg;    // scan index / hit index
    logic [CW-1:0] k_reg;      // shift index
    logic          op_reg;
    logic [15:0]   own_reg;
    logic [16:0]   req_reg;
    logic [2:0]    st_reg;
    logic [15:0]   addr_reg;
    logic [16:0]   len_reg;
    logic          lo_pend_reg; // low merge still to check after high merge

    ffpa_cmp_t cmp;

    ffpa_cmp u_cmp
    (
        .entry_len   (p_len[idx_reg]),
        .req_len     (req_reg),
        .entry_owner (p_owner[idx_reg]),
        .req_owner   (own_reg),
        .cmp         (cmp)
    );

    logic [16:0] msize_sat;
    always_comb
    begin
        msize_sat = ({1'b0, memory_size_data} > CAP) ? CAP[16:0] : memory_size_data;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_DONE);
    assign status     = st_reg;
    assign address    = addr_reg;
    assign length     = len_reg;
    assign free_total = free_reg;

    logic last_hit;
    assign last_hit = ({1'b0, idx_reg} + 1'b1 >= (IW+1)'(count_reg));

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= CW'(1);
            free_reg    <= CAP[16:0];
            lo_pend_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (memory_size_we)
                    begin
                        free_reg  <= msize_sat;
                        count_reg <= CW'(1);
                    end
                    else if (start)
                    begin
                        if (opcode == OP_ALLOC && request_size == '0)
                            state_reg <= S_DONE;
                        else if (opcode == OP_ALLOC && request_size > free_reg)
                            state_reg <= S_DONE;
                        else
                            state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (op_reg == OP_ALLOC && p_free[idx_reg] && cmp.len_ge)
                    begin
                        if (cmp.len_eq)
                        begin
                            free_reg  <= free_reg - req_reg;
                            state_reg <= S_DONE;
                        end
                        else if (count_reg >= CNT_MAX)
                            state_reg <= S_DONE;
                        else
                            state_reg <= S_OPEN;
                    end
                    else if (op_reg == OP_RELEASE && !p_free[idx_reg] && cmp.owner_eq)
                    begin
                        free_reg    <= free_reg + p_len[idx_reg];
                        lo_pend_reg <= 1'b1;
                        state_reg   <= S_MRGHI;
                    end
                    else if (last_hit)
                        state_reg <= S_DONE;
                end
                S_OPEN:
                begin
                    if (k_reg == CW'(idx_reg) + 1'b1)
                        state_reg <= S_SPLIT;
                end
                S_SPLIT:
                begin
                    count_reg <= count_reg + 1'b1;
                    free_reg  <= free_reg - req_reg;
                    state_reg <= S_DONE;
                end
                S_MRGHI:
                begin
                    if (!last_hit && p_free[idx_reg + 1'b1])
                        state_reg <= S_DROP;
                    else
                        state_reg <= S_MRGLO;
                end
                S_MRGLO:
                begin
                    lo_pend_reg <= 1'b0;
                    if (idx_reg != '0 && p_free[idx_reg - 1'b1])
                        state_reg <= S_DROP;
                    else
                        state_reg <= S_DONE;
                end
                S_DROP:
                begin
                    if ({1'b0, k_reg} + 1'b1 >= (CW+1)'(count_reg))
                    begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= lo_pend_reg ? S_MRGLO : S_DONE;
                    end
                end
                S_DONE:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath and table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // one free partition covering all memory
            p_start[0] <= '0;
            p_len[0]   <= CAP[16:0];
            p_free[0]  <= 1'b1;
            p_owner[0] <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (memory_size_we)
                    begin
                        p_start[0] <= '0;
                        p_len[0]   <= msize_sat;
                        p_free[0]  <= 1'b1;
                        p_owner[0] <= '0;
                    end
                    else if (start)
                    begin
                        op_reg   <= opcode;
                        own_reg  <= owner_id;
                        req_reg  <= request_size;
                        idx_reg  <= '0;
                        addr_reg <= '0;
                        len_reg  <= '0;
                        if (opcode == OP_ALLOC)
                            st_reg <= (request_size == '0) ? ST_ZERO : ST_NOSPACE;
                        else
                            st_reg <= ST_NOTFOUND;
                    end
                end
                S_SCAN:
                begin
                    if (op_reg == OP_ALLOC && p_free[idx_reg] && cmp.len_ge)
                    begin
                        if (cmp.len_eq)
                        begin
                            p_free[idx_reg]  <= 1'b0;
                            p_owner[idx_reg] <= own_reg;
                            addr_reg <= p_start[idx_reg];
                            len_reg  <= req_reg;
                            st_reg   <= ST_OK;
                        end
                        else if (count_reg >= CNT_MAX)
                            st_reg <= ST_FULL;
                        else
                            k_reg <= count_reg;
                    end
                    else if (op_reg == OP_RELEASE && !p_free[idx_reg] && cmp.owner_eq)
                    begin
                        addr_reg <= p_start[idx_reg];
                        len_reg  <= p_len[idx_reg];
                        st_reg   <= ST_OK;
                        p_free[idx_reg]  <= 1'b1;
                        p_owner[idx_reg] <= '0;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_OPEN:
                begin
                    // move entry k-1 up to k, walking down to the hit
                    p_start[k_reg[IW-1:0]] <= p_start[k_reg[IW-1:0] - 1'b1];
                    p_len[k_reg[IW-1:0]]   <= p_len[k_reg[IW-1:0] - 1'b1];
                    p_free[k_reg[IW-1:0]]  <= p_free[k_reg[IW-1:0] - 1'b1];
                    p_owner[k_reg[IW-1:0]] <= p_owner[k_reg[IW-1:0] - 1'b1];
                    k_reg <= k_reg - 1'b1;
                end
                S_SPLIT:
                begin
                    p_len[idx_reg]          <= req_reg;
                    p_free[idx_reg]         <= 1'b0;
                    p_owner[idx_reg]        <= own_reg;
                    p_start[idx_reg + 1'b1] <= p_start[idx_reg] + req_reg[15:0];
                    p_len[idx_reg + 1'b1]   <= p_len[idx_reg] - req_reg;
                    addr_reg <= p_start[idx_reg];
                    len_reg  <= req_reg;
                    st_reg   <= ST_OK;
                end
                S_MRGHI:
                begin
                    if (!last_hit && p_free[idx_reg + 1'b1])
                    begin
                        p_len[idx_reg] <= p_len[idx_reg] + p_len[idx_reg + 1'b1];
                        k_reg <= CW'(idx_reg) + 1'b1;
                    end
                end
                S_MRGLO:
                begin
                    if (idx_reg != '0 && p_free[idx_reg - 1'b1])
                    begin
                        p_len[idx_reg - 1'b1] <= p_len[idx_reg - 1'b1] + p_len[idx_reg];
                        k_reg <= CW'(idx_reg);
                    end
                end
                S_DROP:
                begin
                    // move entry k+1 down to k
                    if ({1'b0, k_reg} + 1'b1 < (CW+1)'(count_reg))
                    begin
                        p_start[k_reg[IW-1:0]] <= p_start[k_reg[IW-1:0] + 1'b1];
                        p_len[k_reg[IW-1:0]]   <= p_len[k_reg[IW-1:0] + 1'b1];
                        p_free[k_reg[IW-1:0]]  <= p_free[k_reg[IW-1:0] + 1'b1];
                        p_owner[k_reg[IW-1:0]] <= p_owner[k_reg[IW-1:0] + 1'b1];
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

endmodule

[tb/tb_top.sv]
// testbench for the first-fit partition allocator: predicted results checked beat by beat
`timescale 1ns / 100ps

module tb_top;
    import ffpa_pkg::*;

    localparam int PARTS       = 32;
    localparam int WATCH_LIMIT = 20000;
    localparam int SETTLE      = 2 * PARTS + 10;

    typedef struct packed {
        logic        op;
        logic [15:0] owner;
        logic [16:0] size;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  st;
        logic [15:0] addr;
        logic [16:0] len;
        logic [16:0] free_left;
    } grant_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        opcode;
    logic [15:0] owner_id;
    logic [16:0] request_size;
    logic        memory_size_we;
    logic [16:0] memory_size_data;
    logic        done;
    logic [2:0]  status;
    logic [15:0] address;
    logic [16:0] length;
    logic [16:0] free_total;

    first_fit_partition_allocator_unit #(.MAX_PARTS(PARTS)) dut
    (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .owner_id(owner_id), .request_size(request_size),
        .memory_size_we(memory_size_we), .memory_size_data(memory_size_data),
        .done(done), .status(status), .address(address), .length(length),
        .free_total(free_total)
    );

    // predictor copy of the partition table
    logic [16:0] tbl_start [PARTS];
    logic [16:0] tbl_len   [PARTS];
    logic        tbl_free  [PARTS];
    logic [15:0] tbl_owner [PARTS];
    int          tbl_count;
    logic [16:0] units_free;

    cmd_t   cmd_queue[$];
    grant_t grant_queue[$];
    int     mismatches;
    int     idle_cycles;
    bit     quiet;          // no idling in the last part of the run
    bit     drive_en;
    int     gap_left;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // reinitialise the table as a memory_size write does
    task automatic table_init(input logic [16:0] v);
        logic [16:0] sz;
        sz = (v > 17'd65536) ? 17'd65536 : v;
        for (int k = 0; k < PARTS; k++)
        begin
            tbl_start[k] = '0;
            tbl_len[k]   = '0;
            tbl_free[k]  = 1'b0;
            tbl_owner[k] = '0;
        end
        tbl_len[0]  = sz;
        tbl_free[0] = 1'b1;
        tbl_count   = 1;
        units_free  = sz;
    endtask

    task automatic remove_slot(input int idx);
        for (int k = idx; k + 1 < tbl_count; k++)
        begin
            tbl_start[k] = tbl_start[k+1];
            tbl_len[k]   = tbl_len[k+1];
            tbl_free[k]  = tbl_free[k+1];
            tbl_owner[k] = tbl_owner[k+1];
        end
        tbl_count--;
    endtask

    // work out the result of one accepted command and update the table
    task automatic allocate_or_release(input cmd_t c);
        grant_t g;
        g = '0;
        if (c.op == OP_ALLOC)
        begin
            if (c.size == 0)
                g.st = ST_ZERO;
            else if (c.size > units_free)
                g.st = ST_NOSPACE;
            else
            begin
                g.st = ST_NOSPACE;
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (tbl_free[i] && tbl_len[i] >= c.size)
                    begin
                        if (tbl_len[i] != c.size && tbl_count >= PARTS)
                        begin
                            g.st = ST_FULL;
                            break;
                        end
                        if (tbl_len[i] != c.size)
                        begin
                            // split at the low end, remainder moves up one slot
                            for (int k = tbl_count; k > i; k--)
                            begin
                                tbl_start[k] = tbl_start[k-1];
                                tbl_len[k]   = tbl_len[k-1];
                                tbl_free[k]  = tbl_free[k-1];
                                tbl_owner[k] = tbl_owner[k-1];
                            end
                            tbl_count++;
                            tbl_len[i]     = c.size;
                            tbl_start[i+1] = tbl_start[i] + c.size;
                            tbl_len[i+1]   = tbl_len[i+1] - c.size;
                        end
                        tbl_free[i]  = 1'b0;
                        tbl_owner[i] = c.owner;
                        units_free   = units_free - c.size;
                        g.st   = ST_OK;
                        g.addr = tbl_start[i][15:0];
                        g.len  = c.size;
                        break;
                    end
                end
            end
        end
        else
        begin
            g.st = ST_NOTFOUND;
            for (int i = 0; i < tbl_count; i++)
            begin
                if (!tbl_free[i] && tbl_owner[i] == c.owner)
                begin
                    g.st   = ST_OK;
                    g.addr = tbl_start[i][15:0];
                    g.len  = tbl_len[i];
                    tbl_free[i]  = 1'b1;
                    tbl_owner[i] = '0;
                    units_free   = units_free + tbl_len[i];
                    if (i + 1 < tbl_count && tbl_free[i+1])
                    begin
                        tbl_len[i] = tbl_len[i] + tbl_len[i+1];
                        remove_slot(i + 1);
                    end
                    if (i > 0 && tbl_free[i-1])
                    begin
                        tbl_len[i-1] = tbl_len[i-1] + tbl_len[i];
                        remove_slot(i);
                    end
                    break;
                end
            end
        end
        g.free_left = units_free;
        grant_queue.push_back(g);
    endtask

    // driver: one beat from the queue per handshake, random gaps between beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start        <= 1'b0;
            opcode       <= OP_ALLOC;
            owner_id     <= '0;
            request_size <= '0;
            gap_left     <= 0;
        end
        else
        begin
            if (start && !busy)
                allocate_or_release('{opcode, owner_id, request_size});
            if (start && busy)
                ; // hold the beat until accepted
            else if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (drive_en && cmd_queue.size() > 0)
            begin
                cmd_t c;
                c = cmd_queue.pop_front();
                start        <= 1'b1;
                opcode       <= c.op;
                owner_id     <= c.owner;
                request_size <= c.size;
                if (!quiet && $urandom_range(0, 3) == 0)
                    gap_left <= $urandom_range(1, 15);
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            grant_t exp_g;
            if (grant_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status %0d address %0d", status, address);
            end
            else
            begin
                exp_g = grant_queue.pop_front();
                if (exp_g.st !== status || exp_g.addr !== address
                    || exp_g.len !== length || exp_g.free_left !== free_total)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp st %0d addr %0d len %0d free %0d, got %0d %0d %0d %0d",
                            exp_g.st, exp_g.addr, exp_g.len, exp_g.free_left,
                            status, address, length, free_total);
                end
            end
        end
    end

    // watchdog on cycles with no beat accepted either way
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCH_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic cmd_t make_cmd(input logic o, input logic [15:0] w,
                                      input logic [16:0] s);
        cmd_t c;
        c.op = o;
        c.owner = w;
        c.size = s;
        return c;
    endfunction

    task automatic drain();
        drive_en = 1'b1;
        while (cmd_queue.size() > 0 || start || busy || grant_queue.size() > 0)
            @(posedge clk);
        drive_en = 1'b0;
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_size(input logic [16:0] v);
        @(posedge clk);
        memory_size_we   <= 1'b1;
        memory_size_data <= v;
        @(posedge clk);
        memory_size_we   <= 1'b0;
        table_init(v);
    endtask

    // random phase: mostly allocate/release of a small owner pool
    task automatic random_phase(input int n, input logic [16:0] mem);
        logic [16:0] s;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0: s = 17'($urandom_range(0, 131071));
                1: s = 17'($urandom_range(1, (mem > 0) ? mem : 1));
                default: s = 17'($urandom_range(1, (mem > 64) ? mem / 16 : 4));
            endcase
            if ($urandom_range(0, 19) == 0)
                cmd_queue.push_back(make_cmd(1'($urandom_range(0, 1)),
                    16'($urandom_range(0, 65535)), 17'($urandom_range(0, 131071))));
            else
                cmd_queue.push_back(make_cmd($urandom_range(0, 2) == 0 ? OP_RELEASE
                    : OP_ALLOC, 16'($urandom_range(0, 12)), s));
        end
    endtask

    initial
    begin
        mismatches       = 0;
        idle_cycles      = 0;
        quiet            = 1'b0;
        drive_en         = 1'b0;
        memory_size_we   = 1'b0;
        memory_size_data = '0;
        rst_n            = 1'b0;
        table_init(17'd65536);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2 * PARTS + 10) @(posedge clk);

        // directed: extremes, every status but table full, merges on both sides, last partition
        cmd_queue.push_back(make_cmd(OP_ALLOC, 16'd1, 17'd0));
        cmd_queue.push_back(make_cmd(OP_ALLOC, 16'd1, 17'd65537));
        cmd_queue.push_back(make_cmd(OP_ALLOC, 16'hFFFF, 17'd100));
        cmd_queue.push_back(make_cmd(OP_ALLOC, 16'd0, 17'd200));
        cmd_queue.push_back(make_cmd(OP_ALLOC, 16'd2, 17'd300));
        cmd_queue.push_back(make_cmd(OP_RELEASE, 16'd9, 17'h1FFFF));
        cmd_queue.push_back(make_cmd(OP_RELEASE, 16'hFFFF, 17'd0));
        cmd_queue.push_back(make_cmd(OP_RELEASE, 16'd2, 17'd0));
        cmd_queue.push_back(make_cmd(OP_RELEASE, 16'd0, 17'd0));
        cmd_queue.push_back(make_cmd(OP_ALLOC, 16'd3, 17'd65536));
        cmd_queue.push_back(make_cmd(OP_RELEASE, 16'd3, 17'd0));
        cmd_queue.push_back(make_cmd(OP_ALLOC, 16'd4, 17'd65535));
        cmd_queue.push_back(make_cmd(OP_ALLOC, 16'd5, 17'd1));
        cmd_queue.push_back(make_cmd(OP_RELEASE, 16'd5, 17'd0));
        cmd_queue.push_back(make_cmd(OP_RELEASE, 16'd4, 17'd0));
        drain();

        // fill the table to force the table-full case
        write_size(17'd40);
        for (int i = 0; i < PARTS; i++)
            cmd_queue.push_back(make_cmd(OP_ALLOC, 16'(i + 1), 17'd1));
        cmd_queue.push_back(make_cmd(OP_ALLOC, 16'd7, 17'd8));
        cmd_queue.push_back(make_cmd(OP_ALLOC, 16'd7, 17'd9));
        drain();

        // zero size memory and above-range write
        write_size(17'd0);
        cmd_queue.push_back(make_cmd(OP_ALLOC, 16'd1, 17'd1));
        cmd_queue.push_back(make_cmd(OP_RELEASE, 16'd1, 17'd0));
        drain();
        write_size(17'h1FFFF);
        random_phase(60, 17'd65536);
        drain();
        write_size(17'd1);
        random_phase(30, 17'd1);
        drain();
        write_size(17'd100);
        random_phase(125, 17'd100);
        drain();
        write_size(17'd65536);
        random_phase(125, 17'd65536);
        drain();
        quiet = 1'b1;
        write_size(17'd1000);
        random_phase(60, 17'd1000);
        drain();

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[first_fit_partition_allocator_unit.f]
rtl/core/ffpa_pkg.sv
rtl/core/ffpa_cmp.sv
rtl/core/first_fit_partition_allocator_unit.sv
tb/tb_top.sv
